// ----- design/csgate_pkg.sv -----
// Shared types and constants of the cosine similarity gate.
package csgate_pkg;

    // Accumulator, product and root search widths
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * ACC_W;
    localparam int ROOT_W    = 128;
    localparam int MUL_STEPS = ACC_W;
    localparam int MUL_CW    = 6;
    localparam int SIM_W     = 16;
    localparam int ROOT_BW   = 4;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Operation codes
    localparam logic OP_ENROLL = 1'b0;
    localparam logic OP_JUDGE  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_SHORT_FACTOR   = 2'd1;
    localparam logic [1:0] CFG_FULL_ENROLL    = 2'd2;

    // Reset values of the configuration registers
    localparam logic signed [15:0] BASE_THR_RST    = 16'sd16384;
    localparam logic [15:0]        SHORT_FAC_RST   = 16'd22938;
    localparam logic [23:0]        FULL_ENROLL_RST = 24'd48000;

    // Norm product at or below this counts as a tiny denominator
    localparam logic [PROD_W-1:0] TINY_LIMIT = PROD_W'(115);

    localparam logic signed [SIM_W-1:0] SIM_ONE = 16'sd32767;

    // One finished vector, handed from front to back
    typedef struct packed {
        logic                    kind;
        logic                    short_flag;
        logic signed [15:0]      thr;
        logic                    no_ref;
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        qn;
        logic [ACC_W-1:0]        rn;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ROOT,
        BK_DONE
    } t_back_state;

endpackage

// ----- design/csgate_front.sv -----
// Front part: element intake, reference store, pass control and multiply-accumulate.
module csgate_front #(
    parameter int EMBED_DIM = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_operation,
    input  logic signed [15:0]         i_element,
    input  logic                       i_last_element,
    input  logic [23:0]                i_sample_count,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [23:0]                i_cfg_data,
    input  logic [csgate_pkg::Q_CW-1:0] i_q_free,
    output logic                       o_push,
    output csgate_pkg::t_job           o_job
);
    import csgate_pkg::*;

    localparam int IW = $clog2(EMBED_DIM + 1);
    localparam int AW = $clog2(EMBED_DIM);
    localparam logic [IW-1:0] DIM_L = IW'(EMBED_DIM);

    logic signed [15:0] r_base;
    logic [15:0]        r_factor;
    logic [23:0]        r_full;

    logic [IW-1:0]      r_index;
    logic [IW-1:0]      r_ref_len;
    logic signed [15:0] r_thr;
    logic               r_short;
    logic               r_pass_kind;

    logic signed [15:0] r_mem [EMBED_DIM];
    logic signed [15:0] r_rd;

    logic               r_b_valid, r_b_use, r_b_first, r_b_last, r_b_kind, r_b_short, r_b_noref;
    logic signed [15:0] r_b_e, r_b_thr;

    logic               r_c_valid, r_c_first, r_c_last, r_c_kind, r_c_short, r_c_noref;
    logic signed [15:0] r_c_thr;
    logic signed [31:0] r_c_pd;
    logic [31:0]        r_c_pq, r_c_pr;

    logic signed [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0]        r_qn, r_rn;

    logic               w_acc, w_restart, w_in_range, w_use, w_short;
    logic [IW-1:0]      n_cur, w_step, n_index;
    logic signed [32:0] w_prod, w_q;
    logic signed [15:0] w_reduced;
    logic signed [15:0] w_ref;
    logic signed [31:0] w_pd, w_pq, w_pr;
    logic signed [ACC_W-1:0] n_dot;
    logic [ACC_W-1:0]        n_qn, n_rn;
    logic [Q_CW-1:0]    w_inflight;

    // Hold off requests unless the queue has a slot for every vector in flight and one more
    assign w_inflight = Q_CW'(r_b_valid && r_b_last) + Q_CW'(r_c_valid && r_c_last);
    assign o_ready    = i_q_free > w_inflight;
    assign w_acc      = i_valid && o_ready;

    // Pass control: restart on an operation switch, saturate at the store depth
    assign w_restart  = (r_index != '0) && (i_operation != r_pass_kind);
    assign n_cur      = w_restart ? '0 : r_index;
    assign w_in_range = n_cur < DIM_L;
    assign w_step     = w_in_range ? n_cur + IW'(1) : n_cur;
    assign n_index    = i_last_element ? '0 : w_step;
    assign w_use      = (i_operation == OP_JUDGE) && w_in_range && (n_cur < r_ref_len);
    assign w_short    = i_sample_count < r_full;

    // Reduced threshold, floored and saturated
    assign w_prod = $signed({{17{r_base[15]}}, r_base}) * $signed({17'b0, r_factor});
    assign w_q    = w_prod >>> 15;
    always_comb begin
        if (w_q > 33'sd32767) begin
            w_reduced = 16'sh7fff;
        end else if (w_q < -33'sd32768) begin
            w_reduced = 16'sh8000;
        end else begin
            w_reduced = w_q[15:0];
        end
    end

    // Configuration and pass state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_THR_RST;
            r_factor    <= SHORT_FAC_RST;
            r_full      <= FULL_ENROLL_RST;
            r_index     <= '0;
            r_ref_len   <= '0;
            r_thr       <= BASE_THR_RST;
            r_short     <= 1'b0;
            r_pass_kind <= OP_ENROLL;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_THRESHOLD: r_base   <= i_cfg_data[15:0];
                    CFG_SHORT_FACTOR:   r_factor <= i_cfg_data[15:0];
                    CFG_FULL_ENROLL:    r_full   <= i_cfg_data;
                    default:            ;
                endcase
            end
            if (w_acc) begin
                r_index     <= n_index;
                r_pass_kind <= i_operation;
                if (i_operation == OP_ENROLL && i_last_element) begin
                    r_ref_len <= w_step;
                    r_short   <= w_short;
                    r_thr     <= w_short ? w_reduced : r_base;
                end
            end
            r_b_valid <= w_acc;
            r_c_valid <= r_b_valid;
        end
    end

    // Reference store: write on enroll, registered read on judge
    always_ff @(posedge i_clk) begin
        if (w_acc && w_in_range) begin
            if (i_operation == OP_ENROLL) begin
                r_mem[n_cur[AW-1:0]] <= i_element;
            end else begin
                r_rd <= r_mem[n_cur[AW-1:0]];
            end
        end
    end

    // Stage B: capture the element and its tags
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b_e     <= i_element;
            r_b_use   <= w_use;
            r_b_first <= (n_cur == '0);
            r_b_last  <= i_last_element;
            r_b_kind  <= i_operation;
            r_b_short <= (i_operation == OP_ENROLL) ? w_short : r_short;
            r_b_thr   <= r_thr;
            r_b_noref <= (r_ref_len == '0);
        end
    end

    // Multiply the element with its reference entry
    assign w_ref = r_b_use ? r_rd : 16'sd0;
    assign w_pd  = r_b_e * w_ref;
    assign w_pq  = r_b_use ? r_b_e * r_b_e : 32'sd0;
    assign w_pr  = w_ref * w_ref;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_pd    <= w_pd;
            r_c_pq    <= w_pq;
            r_c_pr    <= w_pr;
            r_c_first <= r_b_first;
            r_c_last  <= r_b_last;
            r_c_kind  <= r_b_kind;
            r_c_short <= r_b_short;
            r_c_thr   <= r_b_thr;
            r_c_noref <= r_b_noref;
        end
    end

    // Stage C: accumulate, restarting on the first element of a pass
    assign n_dot = (r_c_first ? '0 : r_dot) + {{(ACC_W-32){r_c_pd[31]}}, r_c_pd};
    assign n_qn  = (r_c_first ? '0 : r_qn) + {{(ACC_W-32){1'b0}}, r_c_pq};
    assign n_rn  = (r_c_first ? '0 : r_rn) + {{(ACC_W-32){1'b0}}, r_c_pr};

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_dot <= n_dot;
            r_qn  <= n_qn;
            r_rn  <= n_rn;
        end
    end

    // Hand the finished vector to the queue
    assign o_push           = r_c_valid && r_c_last;
    assign o_job.kind       = r_c_kind;
    assign o_job.short_flag = r_c_short;
    assign o_job.thr        = r_c_thr;
    assign o_job.no_ref     = r_c_noref;
    assign o_job.dot        = n_dot;
    assign o_job.qn         = n_qn;
    assign o_job.rn         = n_rn;

endmodule

// ----- design/csgate_queue.sv -----
// Short job queue between the front and back parts.
module csgate_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  csgate_pkg::t_job            i_job,
    output logic [csgate_pkg::Q_CW-1:0] o_free,
    output logic                        o_valid,
    input  logic                        i_pop,
    output csgate_pkg::t_job            o_job
);
    import csgate_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_count;
    logic            w_pop;

    assign o_free  = Q_CW'(Q_DEPTH) - r_count;
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(w_pop);
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- design/csgate_back.sv -----
// Back part: norm products, square-root search for the ratio, verdict and result register.
module csgate_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  csgate_pkg::t_job   i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_finished_kind,
    output logic signed [15:0] o_similarity,
    output logic               o_accepted,
    output logic               o_short_enrollment
);
    import csgate_pkg::*;

    t_back_state r_state, n_state;

    logic                    r_kind, r_short, r_neg;
    logic signed [15:0]      r_thr;
    logic signed [SIM_W-1:0] r_sim;
    logic [PROD_W-1:0]       r_ma, r_mm, r_p, r_m;
    logic [ACC_W-1:0]        r_mb, r_mn;
    logic [MUL_CW-1:0]       r_cnt;
    logic [ROOT_W-1:0]       r_t, r_u, r_r;
    logic [SIM_W-1:0]        r_s;
    logic [ROOT_BW-1:0]      r_bit;
    logic                    r_out_valid, r_out_kind, r_out_acc, r_out_short;
    logic signed [15:0]      r_out_sim;

    logic [ACC_W-1:0]        w_mag;
    logic [PROD_W-1:0]       n_p, n_m;
    logic                    w_mul_end, w_tiny;
    logic [ROOT_W-1:0]       w_trial, w_u_add;
    logic                    w_fit;
    logic [SIM_W-1:0]        n_s, w_bit_mask;
    logic                    w_out_free;

    // Saturate the root to Q1.15 and apply the sign of the dot product
    function automatic logic signed [SIM_W-1:0] sat_sim(input logic [SIM_W-1:0] s,
                                                        input logic neg);
        logic [SIM_W:0] m;
        logic [SIM_W:0] d;
        m = (s > 16'd32768) ? 17'd32768 : {1'b0, s};
        d = 17'd0 - m;
        if (neg) begin
            return d[SIM_W-1:0];
        end
        return (s > 16'd32767) ? SIM_ONE : s;
    endfunction

    assign w_mag = i_job.dot[ACC_W-1] ? ACC_W'(-i_job.dot) : i_job.dot;

    // Shift-add multiply for both norm product and squared dot
    assign n_p       = r_p + (r_mb[0] ? r_ma : '0);
    assign n_m       = r_m + (r_mn[0] ? r_mm : '0);
    assign w_mul_end = r_cnt == MUL_CW'(MUL_STEPS - 1);
    assign w_tiny    = n_p <= TINY_LIMIT;

    // Root search step: try setting the current bit
    assign w_trial    = r_t + (r_u << ({1'b0, r_bit} + 5'd1))
                        + ({{(ROOT_W-PROD_W){1'b0}}, r_p} << {r_bit, 1'b0});
    assign w_u_add    = {{(ROOT_W-PROD_W){1'b0}}, r_p} << r_bit;
    assign w_fit      = w_trial <= r_r;
    assign w_bit_mask = SIM_W'(1) << r_bit;
    assign n_s        = w_fit ? (r_s | w_bit_mask) : r_s;

    assign w_out_free = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    if (i_job.kind == OP_ENROLL || i_job.no_ref) begin
                        n_state = BK_DONE;
                    end else begin
                        n_state = BK_MUL;
                    end
                end
            end
            BK_MUL: begin
                if (w_mul_end) begin
                    n_state = w_tiny ? BK_DONE : BK_ROOT;
                end
            end
            BK_ROOT: begin
                if (r_bit == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_kind  <= i_job.kind;
                r_short <= i_job.short_flag;
                r_thr   <= i_job.thr;
                r_neg   <= i_job.dot[ACC_W-1];
                r_sim   <= (i_job.kind == OP_ENROLL) ? 16'sd0 : SIM_ONE;
                r_ma    <= {{(PROD_W-ACC_W){1'b0}}, i_job.qn};
                r_mb    <= i_job.rn;
                r_mm    <= {{(PROD_W-ACC_W){1'b0}}, w_mag};
                r_mn    <= w_mag;
                r_p     <= '0;
                r_m     <= '0;
                r_cnt   <= '0;
            end
            BK_MUL: begin
                r_p   <= n_p;
                r_m   <= n_m;
                r_ma  <= r_ma << 1;
                r_mm  <= r_mm << 1;
                r_mb  <= r_mb >> 1;
                r_mn  <= r_mn >> 1;
                r_cnt <= r_cnt + MUL_CW'(1);
                r_sim <= 16'sd0;
                r_t   <= '0;
                r_u   <= '0;
                r_s   <= '0;
                r_bit <= ROOT_BW'(SIM_W - 1);
                r_r   <= ROOT_W'({n_m, 30'b0});
            end
            BK_ROOT: begin
                if (w_fit) begin
                    r_t <= w_trial;
                    r_u <= r_u + w_u_add;
                end
                r_s   <= n_s;
                r_bit <= r_bit - ROOT_BW'(1);
                r_sim <= sat_sim(n_s, r_neg);
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == BK_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_DONE && w_out_free) begin
            r_out_kind  <= r_kind;
            r_out_sim   <= r_sim;
            r_out_acc   <= r_kind && (r_sim >= r_thr);
            r_out_short <= r_short;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_finished_kind    = r_out_kind;
    assign o_similarity       = r_out_sim;
    assign o_accepted         = r_out_acc;
    assign o_short_enrollment = r_out_short;

endmodule

// ----- design/cosine_similarity_gate_top.sv -----
// Top level of the cosine similarity gate.
// The gate takes one embedding element per cycle while ready; enroll passes fill the reference
// store and judge passes multiply-accumulate against it in a three-stage front pipeline. Each
// finished vector goes into a four-entry queue; the back part turns a judgement into a
// similarity with a shift-add multiply for the norm product and squared dot product, then a
// square-root search. A judgement with a tiny norm product skips the root search, and an
// enrollment or a judgement without reference skips both; the back part stays busy while the
// result register waits on the receiver. Element intake stalls unless the queue has a free
// slot beyond every vector already in flight. The reference store holds EMBED_DIM entries.
module cosine_similarity_gate_top #(
    parameter int EMBED_DIM = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic signed [15:0] i_element,
    input  logic               i_last_element,
    input  logic [23:0]        i_sample_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_finished_kind,
    output logic signed [15:0] o_similarity,
    output logic               o_accepted,
    output logic               o_short_enrollment,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import csgate_pkg::*;

    logic            w_push, w_q_valid, w_pop;
    logic [Q_CW-1:0] w_q_free;
    t_job            w_push_job, w_pop_job;

    csgate_front #(.EMBED_DIM(EMBED_DIM)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_element      (i_element),
        .i_last_element (i_last_element),
        .i_sample_count (i_sample_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_free       (w_q_free),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    csgate_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_free  (w_q_free),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_pop_job)
    );

    csgate_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (w_q_valid),
        .i_job              (w_pop_job),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_finished_kind    (o_finished_kind),
        .o_similarity       (o_similarity),
        .o_accepted         (o_accepted),
        .o_short_enrollment (o_short_enrollment)
    );

`ifndef NO_ASSERTIONS
    // A finished vector always finds a free queue slot
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_free != '0)
        else $error("job pushed into a full queue");

    // Enrollment results carry no similarity and no verdict
    a_enroll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished_kind == OP_ENROLL) |-> (o_similarity == 16'sd0 && !o_accepted))
        else $error("enrollment result with similarity or verdict");

    // The back part takes a job only when the queue offers one
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from an empty queue");
`endif

endmodule

// ----- tb/cosine_similarity_gate_top_tb.sv -----
// Self-checking testbench of the cosine similarity gate top level.
module cosine_similarity_gate_top_tb;
    import csgate_pkg::*;

    localparam int DIM = 256;

    typedef struct {
        logic               op;
        logic signed [15:0] elem;
        logic               last;
        logic [23:0]        samples;
    } t_element_req;

    typedef struct {
        logic               kind;
        logic signed [15:0] sim;
        logic               acc;
        logic               short_en;
    } t_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_operation = OP_ENROLL;
    logic signed [15:0] i_element = '0;
    logic               i_last_element = 1'b0;
    logic [23:0]        i_sample_count = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_finished_kind;
    logic signed [15:0] o_similarity;
    logic               o_accepted;
    logic               o_short_enrollment;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_BASE_THRESHOLD;
    logic [23:0]        i_cfg_data = '0;

    t_element_req pending_reqs[$];
    t_verdict     expected_verdicts[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           failed = 1'b0;

    // Model state of the gate
    logic signed [15:0] m_base;
    logic [15:0]        m_factor;
    logic [23:0]        m_full;
    logic signed [15:0] m_ref[DIM];
    int                 m_ref_len;
    logic signed [15:0] m_thr;
    logic               m_short;
    int                 m_idx;
    longint             m_dot;
    logic [63:0]        m_qn;
    logic [63:0]        m_rn;
    logic               m_kind;

    // Reference vector as the generator last built it
    logic signed [15:0] gen_ref[DIM];
    int                 gen_len;

    cosine_similarity_gate_top #(.EMBED_DIM(DIM)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] reduced_threshold();
        longint p;
        p = longint'(m_base) * longint'(m_factor);
        return sat16(p >>> 15);
    endfunction

    // Exact floor(|dot| * 2^15 / sqrt(qn * rn)) by a bitwise root search, saturated and signed like dot
    function automatic logic signed [15:0] cosine_q15();
        logic [191:0] norm_prod, dot_sq, trial_sq;
        logic [63:0]  mag;
        logic [16:0]  s, trial;
        norm_prod = {128'b0, m_qn} * {128'b0, m_rn};
        if (norm_prod <= 192'd115) return 16'sd0;
        mag = (m_dot < 0) ? 64'(-m_dot) : 64'(m_dot);
        dot_sq = ({128'b0, mag} * {128'b0, mag}) << 30;
        s = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = s | (17'd1 << b);
            trial_sq = {175'b0, trial} * {175'b0, trial};
            if (norm_prod * trial_sq <= dot_sq) s = trial;
        end
        if (s > 17'd32768) s = 17'd32768;
        if (m_dot < 0) return sat16(-longint'(s));
        return sat16(longint'(s));
    endfunction

    function automatic void clear_pass();
        m_idx = 0;
        m_dot = 0;
        m_qn = '0;
        m_rn = '0;
    endfunction

    // Advance the model by one accepted request
    function automatic void predict_element(t_element_req r);
        t_verdict v;
        longint   e, rv;
        if (m_idx != 0 && r.op != m_kind) clear_pass();
        m_kind = r.op;
        e = r.elem;
        if (r.op == OP_ENROLL) begin
            if (m_idx < DIM) begin
                m_ref[m_idx] = r.elem;
                m_idx++;
            end
            if (!r.last) return;
            m_ref_len = m_idx;
            m_short = r.samples < m_full;
            m_thr = m_short ? reduced_threshold() : m_base;
            clear_pass();
            v = '{OP_ENROLL, 16'sd0, 1'b0, m_short};
        end else begin
            if (m_idx < DIM) begin
                if (m_idx < m_ref_len) begin
                    rv = m_ref[m_idx];
                    m_dot += e * rv;
                    m_qn += 64'(e * e);
                    m_rn += 64'(rv * rv);
                end
                m_idx++;
            end
            if (!r.last) return;
            if (m_ref_len == 0) v = '{OP_JUDGE, 16'sd32767, 1'b1, m_short};
            else begin
                v.kind = OP_JUDGE;
                v.sim = cosine_q15();
                v.acc = v.sim >= m_thr;
                v.short_en = m_short;
            end
            clear_pass();
        end
        expected_verdicts.push_back(v);
    endfunction

    // Drive requests from the pending queue, idling at random
    always @(posedge i_clk) begin
        t_element_req r;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                predict_element('{i_operation, i_element, i_last_element, i_sample_count});
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    r = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= r.op;
                    i_element <= r.elem;
                    i_last_element <= r.last;
                    i_sample_count <= r.samples;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result kind %0d sim %0d", $time,
                             o_finished_kind, o_similarity);
                    failed = 1'b1;
                end else begin
                    v = expected_verdicts.pop_front();
                    if (o_finished_kind !== v.kind) begin
                        $display("%0t: finished_kind expected %0d actual %0d", $time,
                                 v.kind, o_finished_kind);
                        failed = 1'b1;
                    end
                    if (o_similarity !== v.sim) begin
                        $display("%0t: similarity expected %0d actual %0d", $time,
                                 v.sim, o_similarity);
                        failed = 1'b1;
                    end
                    if (o_accepted !== v.acc) begin
                        $display("%0t: accepted expected %0d actual %0d", $time,
                                 v.acc, o_accepted);
                        failed = 1'b1;
                    end
                    if (o_short_enrollment !== v.short_en) begin
                        $display("%0t: short_enrollment expected %0d actual %0d", $time,
                                 v.short_en, o_short_enrollment);
                        failed = 1'b1;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BASE_THRESHOLD) m_base = value[15:0];
        else if (idx == CFG_SHORT_FACTOR) m_factor = value[15:0];
        else if (idx == CFG_FULL_ENROLL) m_full = value;
    endtask

    function automatic logic signed [15:0] pick_element();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_samples();
        case ($urandom_range(5))
            0: return 24'd0;
            1: return m_full - 24'd1;
            2: return m_full;
            3: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Queue one vector; style picks random, reference copy, negated copy, zero or shifted noisy copy
    task automatic push_vector(logic op, int len, int style, logic [23:0] samples, bit finish);
        t_element_req r;
        logic signed [15:0] e;
        longint scaled;
        int shift;
        shift = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            case (style)
                1: e = (i < gen_len) ? gen_ref[i] : pick_element();
                2: begin
                    scaled = (i < gen_len) ? -longint'(gen_ref[i]) : 0;
                    e = sat16(scaled);
                end
                3: e = 16'sd0;
                4: begin
                    scaled = (i < gen_len) ? (longint'(gen_ref[i]) >>> shift) : 0;
                    e = 16'(scaled + $signed($urandom_range(200)) - 100);
                end
                default: e = pick_element();
            endcase
            if (op == OP_ENROLL && i < DIM) gen_ref[i] = e;
            r = '{op, e, finish && (i == len - 1), 24'($urandom)};
            if (r.last) r.samples = samples;
            pending_reqs.push_back(r);
        end
        if (op == OP_ENROLL && finish) gen_len = (len > DIM) ? DIM : len;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || i_valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic random_traffic(int n_items);
        int target;
        int len;
        target = pending_reqs.size() + n_items;
        while (pending_reqs.size() < target) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 12);
            case ($urandom_range(9))
                0, 1: push_vector(OP_ENROLL, len, 0, pick_samples(), 1'b1);
                2, 3: push_vector(OP_JUDGE, len, 1, 24'd0, 1'b1);
                4: push_vector(OP_JUDGE, len, 2, 24'd0, 1'b1);
                5, 6: push_vector(OP_JUDGE, len, 4, 24'd0, 1'b1);
                7: push_vector(OP_JUDGE, len, 0, 24'd0, 1'b1);
                // broken pass: no last element, so a following pass of the other operation abandons it
                8: push_vector($urandom_range(1), $urandom_range(1, 6), 0, 24'd0, 1'b0);
                default: push_vector(OP_JUDGE, len, 3, 24'd0, 1'b1);
            endcase
        end
    endtask

    initial begin
        m_base = BASE_THR_RST;
        m_factor = SHORT_FAC_RST;
        m_full = FULL_ENROLL_RST;
        m_ref_len = 0;
        m_thr = BASE_THR_RST;
        m_short = 1'b0;
        m_kind = OP_ENROLL;
        gen_len = 0;
        clear_pass();
        send_idle_pct = 29;
        recv_idle_pct = 72;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no enrollment, zero reference, extremes, negation, short enrollment
        push_vector(OP_JUDGE, 1, 0, 24'd0, 1'b1);
        push_vector(OP_ENROLL, 2, 3, 24'hFFFFFF, 1'b1);
        push_vector(OP_JUDGE, 2, 0, 24'd0, 1'b1);
        gen_ref[0] = -16'sd32768;
        gen_ref[1] = 16'sd32767;
        gen_len = 2;
        push_vector(OP_ENROLL, 2, 1, 24'd0, 1'b1);
        push_vector(OP_JUDGE, 2, 1, 24'd0, 1'b1);
        push_vector(OP_JUDGE, 2, 2, 24'd0, 1'b1);
        push_vector(OP_JUDGE, 3, 0, 24'd0, 1'b1);
        push_vector(OP_JUDGE, 1, 0, 24'd0, 1'b0);
        push_vector(OP_ENROLL, 3, 0, FULL_ENROLL_RST - 24'd1, 1'b1);
        push_vector(OP_JUDGE, 3, 4, 24'd0, 1'b1);
        push_vector(OP_ENROLL, 1, 0, FULL_ENROLL_RST, 1'b1);
        push_vector(OP_JUDGE, 1, 1, 24'd0, 1'b1);

        for (int seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 29 : (seg < 4) ? 72 : 0;
            recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 29 : 0;
            wait_idle();
            case (seg)
                1: begin
                    write_reg(CFG_BASE_THRESHOLD, 24'h008000);
                    write_reg(CFG_SHORT_FACTOR, 24'd32768);
                    write_reg(CFG_FULL_ENROLL, 24'd0);
                end
                2: begin
                    write_reg(CFG_BASE_THRESHOLD, 24'h007FFF);
                    write_reg(CFG_SHORT_FACTOR, 24'd0);
                    write_reg(CFG_FULL_ENROLL, 24'hFFFFFF);
                end
                3: begin
                    write_reg(CFG_BASE_THRESHOLD, 24'h00C000);
                    write_reg(CFG_SHORT_FACTOR, 24'd32768);
                    write_reg(CFG_FULL_ENROLL, 24'($urandom));
                end
                4, 5: begin
                    write_reg(CFG_BASE_THRESHOLD, 24'($urandom_range(65535)));
                    write_reg(CFG_SHORT_FACTOR, 24'($urandom_range(32768)));
                    write_reg(CFG_FULL_ENROLL, 24'($urandom));
                end
                default: ;
            endcase
            random_traffic(265);
        end

        wait_idle();
        if (!failed) $display("cosine_similarity_gate_top_tb: PASS");
        else $display("cosine_similarity_gate_top_tb: FAIL");
        $finish;
    end

    // Hold a hard limit on the run
    initial begin
        #30000000;
        $display("cosine_similarity_gate_top_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/csgate_pkg.sv
design/csgate_front.sv
design/csgate_queue.sv
design/csgate_back.sv
design/cosine_similarity_gate_top.sv
tb/cosine_similarity_gate_top_tb.sv
